/* design/beep_pattern_generator_top_defines.svh */
// Assertion macros used by the checker file of the beep pattern generator.
`ifndef BEEP_PATTERN_GENERATOR_TOP_DEFINES_SVH
`define BEEP_PATTERN_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and quiet while i_rst_n is low.
`define BPG_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and quiet while i_rst_n is low.
`define BPG_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/bpg_pkg.sv */
// Types and constants shared by the beep pattern generator modules.
`default_nettype none

package bpg_pkg;

    localparam int PRIMARY_FREQ = 1000000;
    localparam int MILLI        = 1000;
    localparam int PERCENT      = 100;

    localparam int FREQ_W   = 26;
    localparam int RELOAD_W = 30;
    localparam int PROD_W   = 23;
    localparam int TGT_W    = 8;

    localparam logic [RELOAD_W-1:0] DIVIDEND   = RELOAD_W'(PRIMARY_FREQ * MILLI);
    localparam logic [RELOAD_W-1:0] RELOAD_MAX = RELOAD_W'(PRIMARY_FREQ * MILLI - 1);
    localparam int DIV_STEPS = RELOAD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for every x below 2**23.
    localparam int RECIP_SHIFT = 30;
    localparam logic [23:0] RECIP_100 = 24'd10737419;
    localparam int SCALE_W = PROD_W + 24;

    localparam logic [6:0] DUTY_MAX = 7'(PERCENT);

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    localparam logic [1:0] FUNC_PATTERN   = 2'd0;
    localparam logic [1:0] FUNC_TICK      = 2'd1;
    localparam logic [1:0] FUNC_FORCE_ON  = 2'd2;
    localparam logic [1:0] FUNC_FORCE_OFF = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_SOUND  = 2'd1,
        PH_SILENT = 2'd2,
        PH_CONT   = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        CMD_PATTERN,
        CMD_TICK,
        CMD_FORCE_ON,
        CMD_FORCE_OFF
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind           kind;
        logic [FREQ_W-1:0]   freq_mhz;
        logic [PROD_W-1:0]   prod_on;
        logic [PROD_W-1:0]   prod_off;
        logic [TGT_W-1:0]    target;
    } t_cmd;

endpackage

`default_nettype wire

/* design/bpg_front.sv */
// Front end: accepts input beats, classifies them and queues the commands.
`default_nettype none

module bpg_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_func,
    input  wire logic [15:0]        i_freq_hz,
    input  wire logic [15:0]        i_cycle_time_ms,
    input  wire logic [6:0]         i_duty_percent,
    input  wire logic [7:0]         i_cycle_target,
    input  wire logic [25:0]        i_freq_millihertz,
    output bpg_pkg::t_cmd           o_head,
    output logic                    o_head_valid,
    input  wire logic               i_pop
);
    import bpg_pkg::*;

    t_cmd                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr;
    logic [Q_PTR_W:0]    r_count;
    t_cmd                cmd;
    logic [6:0]          duty_sat;
    logic                push;
    logic                pop;

    always_comb begin
        duty_sat = (i_duty_percent > DUTY_MAX) ? DUTY_MAX : i_duty_percent;
        cmd.prod_on  = PROD_W'(i_cycle_time_ms) * PROD_W'(duty_sat);
        cmd.prod_off = PROD_W'(i_cycle_time_ms) * PROD_W'(DUTY_MAX - duty_sat);
        cmd.target   = i_cycle_target;
        cmd.freq_mhz = i_freq_millihertz;
        case (i_func)
            FUNC_PATTERN: begin
                cmd.kind     = CMD_PATTERN;
                cmd.freq_mhz = FREQ_W'(i_freq_hz) * FREQ_W'(MILLI);
            end
            FUNC_TICK:      cmd.kind = CMD_TICK;
            FUNC_FORCE_ON:  cmd.kind = CMD_FORCE_ON;
            default:        cmd.kind = CMD_FORCE_OFF;
        endcase
    end

    assign o_in_stall   = (r_count == (Q_PTR_W + 1)'(Q_DEPTH));
    assign push         = i_in_valid && !o_in_stall;
    assign o_head_valid = (r_count != '0);
    assign pop          = i_pop && o_head_valid;
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + (Q_PTR_W + 1)'(1);
            end else if (pop && !push) begin
                r_count <= r_count - (Q_PTR_W + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= cmd;
        end
    end

endmodule

`default_nettype wire

/* design/bpg_div.sv */
// Restoring divider that turns a frequency in millihertz into a timer reload value.
`default_nettype none

module bpg_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [bpg_pkg::FREQ_W-1:0]    i_divisor,
    output logic                               o_done,
    output logic [bpg_pkg::RELOAD_W-1:0]       o_reload
);
    import bpg_pkg::*;

    typedef enum logic {DV_IDLE, DV_RUN} t_dv_state;

    t_dv_state             r_state;
    logic [FREQ_W:0]       r_rem;
    logic [RELOAD_W-1:0]   r_dvd;
    logic [RELOAD_W-1:0]   r_quo;
    logic [FREQ_W-1:0]     r_div;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic                  r_zero;
    logic                  r_done;
    logic [FREQ_W:0]       rem_sh;
    logic                  fits;

    // One quotient bit per cycle: shift in the next dividend bit, subtract if it fits.
    assign rem_sh = {r_rem[FREQ_W-1:0], r_dvd[RELOAD_W-1]};
    assign fits   = (rem_sh >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                DV_IDLE: begin
                    if (i_start) begin
                        r_state <= DV_RUN;
                        r_cnt   <= '0;
                        r_rem   <= '0;
                        r_dvd   <= DIVIDEND;
                        r_quo   <= '0;
                        r_div   <= i_divisor;
                        r_zero  <= (i_divisor == '0);
                    end
                end
                DV_RUN: begin
                    r_rem <= fits ? (rem_sh - {1'b0, r_div}) : rem_sh;
                    r_quo <= {r_quo[RELOAD_W-2:0], fits};
                    r_dvd <= {r_dvd[RELOAD_W-2:0], 1'b0};
                    r_cnt <= r_cnt + DIV_CNT_W'(1);
                    if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= DV_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= DV_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_reload = r_zero ? RELOAD_MAX : (r_quo - RELOAD_W'(1));

endmodule

`default_nettype wire

/* design/bpg_back.sv */
// Back end: executes queued commands, keeps the pattern state and holds the result.
`default_nettype none

module bpg_back #(
    parameter int COUNT_BITS = 8,
    parameter int TIME_BITS  = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_wdata,
    input  wire bpg_pkg::t_cmd                 i_head,
    input  wire logic                          i_head_valid,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_tone_on,
    output logic [bpg_pkg::RELOAD_W-1:0]       o_reload_value,
    output logic [1:0]                         o_phase,
    output logic [TIME_BITS-1:0]               o_ticks_left
);
    import bpg_pkg::*;

    typedef enum logic [1:0] {B_IDLE, B_SCALE, B_WAIT} t_state;

    t_state                 r_state,       n_state;
    t_cmd                   r_cmd;
    logic                   r_buzzer_enable;
    logic                   r_out_valid,   n_out_valid;
    t_phase                 r_phase,       n_phase;
    logic [COUNT_BITS-1:0]  r_beep_count,  n_beep_count;
    logic [COUNT_BITS-1:0]  r_beep_target, n_beep_target;
    logic [TIME_BITS-1:0]   r_on_time,     n_on_time;
    logic [TIME_BITS-1:0]   r_off_time,    n_off_time;
    logic [TIME_BITS-1:0]   r_remaining,   n_remaining;
    logic                   r_tone,        n_tone;
    logic [RELOAD_W-1:0]    r_reload,      n_reload;

    logic [SCALE_W-1:0]     scaled_on;
    logic [SCALE_W-1:0]     scaled_off;
    logic [COUNT_BITS-1:0]  count_inc;
    logic                   div_start;
    logic                   div_done;
    logic [RELOAD_W-1:0]    div_reload;

    bpg_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_divisor (r_cmd.freq_mhz),
        .o_done    (div_done),
        .o_reload  (div_reload)
    );

    assign o_pop     = (r_state == B_IDLE) && i_head_valid && !r_out_valid;
    assign div_start = (r_state == B_SCALE);
    assign scaled_on  = SCALE_W'(r_cmd.prod_on)  * SCALE_W'(RECIP_100);
    assign scaled_off = SCALE_W'(r_cmd.prod_off) * SCALE_W'(RECIP_100);
    assign count_inc  = r_beep_count + COUNT_BITS'(1);

    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid && i_out_stall;
        n_phase       = r_phase;
        n_beep_count  = r_beep_count;
        n_beep_target = r_beep_target;
        n_on_time     = r_on_time;
        n_off_time    = r_off_time;
        n_remaining   = r_remaining;
        n_tone        = r_tone;
        n_reload      = r_reload;
        case (r_state)
            B_IDLE: begin
                if (o_pop) begin
                    case (i_head.kind)
                        CMD_PATTERN: begin
                            if (r_phase == PH_IDLE && r_buzzer_enable) begin
                                n_state = B_SCALE;
                            end else begin
                                n_out_valid = 1'b1;
                            end
                        end
                        CMD_TICK: begin
                            n_out_valid = 1'b1;
                            if (r_phase == PH_SOUND || r_phase == PH_SILENT) begin
                                if (r_remaining > TIME_BITS'(1)) begin
                                    n_remaining = r_remaining - TIME_BITS'(1);
                                end else if (r_phase == PH_SOUND) begin
                                    n_phase = PH_SILENT;
                                    if (r_off_time != '0) begin
                                        n_tone      = 1'b0;
                                        n_remaining = r_off_time;
                                    end else begin
                                        n_remaining = TIME_BITS'(1);
                                    end
                                end else begin
                                    n_beep_count = count_inc;
                                    if (count_inc == r_beep_target) begin
                                        n_tone      = 1'b0;
                                        n_phase     = PH_IDLE;
                                        n_remaining = '0;
                                    end else begin
                                        n_phase = PH_SOUND;
                                        if (r_on_time != '0) begin
                                            n_tone      = 1'b1;
                                            n_remaining = r_on_time;
                                        end else begin
                                            n_remaining = TIME_BITS'(1);
                                        end
                                    end
                                end
                            end
                        end
                        CMD_FORCE_ON: n_state = B_SCALE;
                        default: begin
                            n_out_valid = 1'b1;
                            n_tone      = 1'b0;
                            n_phase     = PH_IDLE;
                            n_remaining = '0;
                        end
                    endcase
                end
            end
            B_SCALE: begin
                // The divider starts here; a pattern also loads its times and target.
                n_state = B_WAIT;
                if (r_cmd.kind == CMD_PATTERN) begin
                    n_on_time     = TIME_BITS'(scaled_on >> RECIP_SHIFT);
                    n_off_time    = TIME_BITS'(scaled_off >> RECIP_SHIFT);
                    n_beep_target = COUNT_BITS'(r_cmd.target);
                    n_beep_count  = '0;
                end
            end
            B_WAIT: begin
                if (div_done) begin
                    n_state     = B_IDLE;
                    n_out_valid = 1'b1;
                    n_reload    = div_reload;
                    if (r_cmd.kind == CMD_PATTERN) begin
                        n_phase = PH_SOUND;
                        if (r_on_time != '0) begin
                            n_tone      = 1'b1;
                            n_remaining = r_on_time;
                        end else begin
                            n_remaining = TIME_BITS'(1);
                        end
                    end else begin
                        n_tone      = 1'b1;
                        n_phase     = PH_CONT;
                        n_remaining = '0;
                    end
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= B_IDLE;
            r_buzzer_enable <= 1'b1;
            r_out_valid     <= 1'b0;
            r_phase         <= PH_IDLE;
            r_beep_count    <= '0;
            r_beep_target   <= '0;
            r_on_time       <= '0;
            r_off_time      <= '0;
            r_remaining     <= '0;
            r_tone          <= 1'b0;
            r_reload        <= '0;
        end else begin
            r_state       <= n_state;
            r_out_valid   <= n_out_valid;
            r_phase       <= n_phase;
            r_beep_count  <= n_beep_count;
            r_beep_target <= n_beep_target;
            r_on_time     <= n_on_time;
            r_off_time    <= n_off_time;
            r_remaining   <= n_remaining;
            r_tone        <= n_tone;
            r_reload      <= n_reload;
            if (i_cfg_we) begin
                r_buzzer_enable <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_head;
        end
    end

    // The state registers are the result: they only move once the last beat is taken.
    assign o_out_valid    = r_out_valid;
    assign o_tone_on      = r_tone;
    assign o_reload_value = r_reload;
    assign o_phase        = r_phase;
    assign o_ticks_left   = r_remaining;

endmodule

`default_nettype wire

/* design/beep_pattern_generator_top.sv */
// Top level of the beep pattern generator: front queue plus executing back end.
//
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    i_func, i_freq_hz, i_cycle_time_ms,
//                                                 i_duty_percent, i_cycle_target,
//                                                 i_freq_millihertz
// output    out        o_out_valid / i_out_stall  o_tone_on, o_reload_value, o_phase,
//                                                 o_ticks_left
// config    in         i_cfg_we                   i_cfg_wdata (buzzer enable)
//
// Ticks, force-off beats and refused pattern requests pass from the queue straight into the
// result registers once the back end pops them. Pattern requests and force-on beats first wait
// for the divider, which yields one bit of the 30-bit reload value per cycle.
// Reset is synchronous and needs no clearing pass; the enable register comes up set.
// A four-beat queue keeps taking input beats while a result waits on i_out_stall.
`default_nettype none

module beep_pattern_generator_top #(
    parameter int COUNT_BITS = 8,
    parameter int TIME_BITS  = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic                   i_cfg_wdata,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [1:0]             i_func,
    input  wire logic [15:0]            i_freq_hz,
    input  wire logic [15:0]            i_cycle_time_ms,
    input  wire logic [6:0]             i_duty_percent,
    input  wire logic [7:0]             i_cycle_target,
    input  wire logic [25:0]            i_freq_millihertz,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic                        o_tone_on,
    output logic [29:0]                 o_reload_value,
    output logic [1:0]                  o_phase,
    output logic [TIME_BITS-1:0]        o_ticks_left
);
    import bpg_pkg::*;

    t_cmd head;
    logic head_valid;
    logic pop;

    // The front end sorts, pre-multiplies and buffers; all pattern state lives in the back end.
    bpg_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_func            (i_func),
        .i_freq_hz         (i_freq_hz),
        .i_cycle_time_ms   (i_cycle_time_ms),
        .i_duty_percent    (i_duty_percent),
        .i_cycle_target    (i_cycle_target),
        .i_freq_millihertz (i_freq_millihertz),
        .o_head            (head),
        .o_head_valid      (head_valid),
        .i_pop             (pop)
    );

    // The back end takes one command at a time and only when its result slot is free.
    bpg_back #(
        .COUNT_BITS (COUNT_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_head         (head),
        .i_head_valid   (head_valid),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_tone_on      (o_tone_on),
        .o_reload_value (o_reload_value),
        .o_phase        (o_phase),
        .o_ticks_left   (o_ticks_left)
    );

endmodule

`default_nettype wire

/* design/bpg_checker.sv */
// Port-level checks for the beep pattern generator, bound to its top level.
`default_nettype none
`include "beep_pattern_generator_top_defines.svh"

module bpg_checker #(
    parameter int TIME_BITS = 16
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_stall,
    input wire logic                  o_tone_on,
    input wire logic [29:0]           o_reload_value,
    input wire logic [1:0]            o_phase,
    input wire logic [TIME_BITS-1:0]  o_ticks_left
);
    import bpg_pkg::*;

    `BPG_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_tone_on) && $stable(o_reload_value) && $stable(o_phase) && $stable(o_ticks_left), "stalled result beat changed")
    `BPG_ASSERT_IMP(a_idle_quiet, o_out_valid && (o_phase == PH_IDLE), !o_tone_on && (o_ticks_left == '0), "idle phase with tone or ticks left")
    `BPG_ASSERT_IMP(a_cont_on, o_out_valid && (o_phase == PH_CONT), o_tone_on && (o_ticks_left == '0), "continuous phase without tone or with ticks left")
    `BPG_ASSERT_IMP(a_pattern_ticks, o_out_valid && ((o_phase == PH_SOUND) || (o_phase == PH_SILENT)), o_ticks_left != '0, "pattern phase with no ticks left")

endmodule

bind beep_pattern_generator_top bpg_checker #(.TIME_BITS(TIME_BITS)) u_bpg_checker (.*);

`default_nettype wire
